// File: rtl/opl_pkg.sv
`timescale 1ns / 1ps
package opl_pkg;

  // Request kinds carried on the slave tuser
  typedef enum logic [2:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_GET    = 3'd3,
    REQ_CLEAR  = 3'd4,
    REQ_RESIZE = 3'd5
  } req_t;

  // Result status carried on the master tuser
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NEG    = 2'd1,
    ST_BEYOND = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // What each cell does with its neighbors
  typedef enum logic [1:0] {
    MOVE_HOLD  = 2'd0,
    MOVE_UP    = 2'd1,
    MOVE_DOWN  = 2'd2,
    MOVE_ZERO  = 2'd3
  } move_t;

  localparam int IDX_W   = 8;
  localparam int REQ_W   = 3;
  localparam int STAT_W  = 2;
  localparam int POS_W   = 8;
  localparam int PORT_CW = 16;
  localparam int COUNT_W = 5;

  // Broadcast to every cell: MOVE_UP takes the left neighbor for lo < i <= hi,
  // MOVE_DOWN takes the right neighbor and MOVE_ZERO clears for lo <= i < hi;
  // wr loads the new point into cell wpos and overrides the move.
  typedef struct packed {
    move_t              move;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic               wr;
    logic [IDX_W-1:0]   wpos;
  } cell_cmd_t;

endpackage

// File: rtl/opl_cell.sv
`timescale 1ns / 1ps
module opl_cell #(
  parameter int IDX        = 0,
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  opl_pkg::cell_cmd_t     cmd,
  input  logic [COORD_BITS-1:0]  pt_x,
  input  logic [COORD_BITS-1:0]  pt_y,
  input  logic [COORD_BITS-1:0]  left_x,
  input  logic [COORD_BITS-1:0]  left_y,
  input  logic [COORD_BITS-1:0]  right_x,
  input  logic [COORD_BITS-1:0]  right_y,
  output logic [COORD_BITS-1:0]  x,
  output logic [COORD_BITS-1:0]  y
);
  import opl_pkg::*;

  localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

  logic [COORD_BITS-1:0] x_next;
  logic [COORD_BITS-1:0] y_next;

  always_comb begin
    x_next = x;
    y_next = y;
    if (cmd.wr && (cmd.wpos == ME)) begin
      x_next = pt_x;
      y_next = pt_y;
    end else begin
      case (cmd.move)
        MOVE_UP: begin
          if ((ME > cmd.lo) && (ME <= cmd.hi)) begin
            x_next = left_x;
            y_next = left_y;
          end
        end
        MOVE_DOWN: begin
          if ((ME >= cmd.lo) && (ME < cmd.hi)) begin
            x_next = right_x;
            y_next = right_y;
          end
        end
        MOVE_ZERO: begin
          if ((ME >= cmd.lo) && (ME < cmd.hi)) begin
            x_next = '0;
            y_next = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
    y <= y_next;
  end

endmodule

// File: rtl/ordered_point_list.sv
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY points held in a row of cells.
//
// Slave stream: one request item per handshake. tuser carries the request
// kind (append, insert, remove, get, clear, resize); tdata carries the
// position (or new length for resize) and the point to store.
// Master stream: one result item per request: status in tuser, and in
// tdata the point read by a successful get (zero otherwise) and the
// number of points held after the request.
//
// The result is registered and appears in the cycle after the request is taken.
// Throughput: one item per cycle while not stalled. All shifted cells move
// in the same cycle, so insert and remove cost the same at any position;
// the output register alone sets the pace.
// Stall: while a result waits on a stalled receiver, s_axis_tready stays
// low and the list holds; a result taken in the same cycle frees the slot.
// Reset: the list is emptied and no result is pending. Cell contents are
// not cleared; growth writes zeros before any cell becomes readable.
module ordered_point_list #(
  parameter int CAPACITY   = 16,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[7:0], in_x[23:8], in_y[39:24]
  input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_x[15:0], out_y[31:16], count[36:32], zero
  output logic [1:0]  m_axis_tuser   // status[1:0]
);
  import opl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SEL_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IDX_W-1:0] CAP_I = IDX_W'(CAPACITY);

  // Stored count of points
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  // Cell row
  logic [COORD_BITS-1:0] cell_x [CAPACITY];
  logic [COORD_BITS-1:0] cell_y [CAPACITY];
  cell_cmd_t             cmd;

  // Request fields
  logic                  accept;
  req_t                  req;
  logic                  neg;
  logic [IDX_W-1:0]      pos;
  logic [IDX_W-1:0]      cur;
  logic signed [15:0]    in_xs;
  logic signed [15:0]    in_ys;
  logic signed [31:0]    in_xw;
  logic signed [31:0]    in_yw;
  logic [COORD_BITS-1:0] pt_x;
  logic [COORD_BITS-1:0] pt_y;

  // Result
  status_t                  stat;
  logic                     rd_ok;
  logic signed [COORD_BITS-1:0] rd_xs;
  logic signed [COORD_BITS-1:0] rd_ys;
  logic signed [31:0]       rd_xw;
  logic signed [31:0]       rd_yw;
  logic [15:0]              out_x;
  logic [15:0]              out_y;
  logic [IDX_W-1:0]         new_cnt;

  // Take a new item whenever the output register is empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign req   = req_t'(s_axis_tuser);
  assign neg   = s_axis_tdata[7];
  assign pos   = {1'b0, s_axis_tdata[6:0]};
  assign cur   = IDX_W'(cnt);
  assign in_xs = s_axis_tdata[23:8];
  assign in_ys = s_axis_tdata[39:24];
  assign in_xw = 32'(in_xs);
  assign in_yw = 32'(in_ys);
  assign pt_x  = in_xw[COORD_BITS-1:0];
  assign pt_y  = in_yw[COORD_BITS-1:0];

  // Decode the request into one broadcast command for the whole row
  always_comb begin
    cmd      = '{move: MOVE_HOLD, lo: '0, hi: '0, wr: 1'b0, wpos: '0};
    stat     = ST_OK;
    rd_ok    = 1'b0;
    new_cnt  = cur;
    case (req)
      REQ_APPEND: begin
        if (cur >= CAP_I) begin
          stat = ST_FULL;
        end else begin
          cmd.wr   = 1'b1;
          cmd.wpos = cur;
          new_cnt  = cur + 1'b1;
        end
      end
      REQ_INSERT: begin
        if (neg) begin
          stat = ST_NEG;
        end else if (pos <= cur) begin
          if (cur >= CAP_I) begin
            stat = ST_FULL;
          end else begin
            // shift the tail up and drop the point into the gap
            cmd.move = MOVE_UP;
            cmd.lo   = pos;
            cmd.hi   = cur;
            cmd.wr   = 1'b1;
            cmd.wpos = pos;
            new_cnt  = cur + 1'b1;
          end
        end else if (pos > CAP_I) begin
          stat = ST_FULL;
        end else begin
          // past the end: zero the gap, new point goes last
          cmd.move = MOVE_ZERO;
          cmd.lo   = cur;
          cmd.hi   = pos - 1'b1;
          cmd.wr   = 1'b1;
          cmd.wpos = pos - 1'b1;
          new_cnt  = pos;
        end
      end
      REQ_REMOVE: begin
        if (neg) begin
          stat = ST_NEG;
        end else if (pos >= cur) begin
          stat = ST_BEYOND;
        end else begin
          cmd.move = MOVE_DOWN;
          cmd.lo   = pos;
          cmd.hi   = cur - 1'b1;
          new_cnt  = cur - 1'b1;
        end
      end
      REQ_GET: begin
        if (neg) begin
          stat = ST_NEG;
        end else if (pos >= cur) begin
          stat = ST_BEYOND;
        end else begin
          rd_ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        new_cnt = '0;
      end
      REQ_RESIZE: begin
        if (neg) begin
          stat = ST_NEG;
        end else if (pos > CAP_I) begin
          stat = ST_FULL;
        end else begin
          if (pos > cur) begin
            cmd.move = MOVE_ZERO;
            cmd.lo   = cur;
            cmd.hi   = pos;
          end
          new_cnt = pos;
        end
      end
      default: begin
      end
    endcase
    // hold everything unless the item is taken this cycle
    if (!accept) begin
      cmd.move = MOVE_HOLD;
      cmd.wr   = 1'b0;
    end
  end

  assign cnt_next = accept ? CNT_W'(new_cnt) : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Row of cells, each wired to its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [COORD_BITS-1:0] lx;
    logic [COORD_BITS-1:0] ly;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
    if (g == 0) begin : g_first
      assign lx = '0;
      assign ly = '0;
    end else begin : g_left
      assign lx = cell_x[g-1];
      assign ly = cell_y[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rx = '0;
      assign ry = '0;
    end else begin : g_right
      assign rx = cell_x[g+1];
      assign ry = cell_y[g+1];
    end
    opl_cell #(
      .IDX        (g),
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .pt_x    (pt_x),
      .pt_y    (pt_y),
      .left_x  (lx),
      .left_y  (ly),
      .right_x (rx),
      .right_y (ry),
      .x       (cell_x[g]),
      .y       (cell_y[g])
    );
  end

  // Read port for get; pos is below count here, so it fits the select
  assign rd_xs = cell_x[pos[SEL_W-1:0]];
  assign rd_ys = cell_y[pos[SEL_W-1:0]];
  assign rd_xw = 32'(rd_xs);
  assign rd_yw = 32'(rd_ys);
  assign out_x = rd_ok ? rd_xw[15:0] : 16'd0;
  assign out_y = rd_ok ? rd_yw[15:0] : 16'd0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {3'd0, new_cnt[COUNT_W-1:0], out_y, out_x};
      m_axis_tuser <= stat;
    end
  end

endmodule

// File: rtl/opl_checker.sv
`timescale 1ns / 1ps
module opl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import opl_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Back-pressure only while a result is pending and not taken
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a pending result");

  // Failed requests return a zero point
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata[31:0] == 32'd0)
    else $error("nonzero point on failed request");

  // Each accepted item leaves a result pending in the following cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("missing result");

  // Nothing pending right after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result pending after reset");

endmodule

bind ordered_point_list opl_checker u_opl_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
